// File: rtl/hi3d_pkg.sv
package hi3d_pkg;

   localparam int COORD_W = 21;
   localparam int INDEX_W = 63;
   localparam int AXES = 3;

   // Curve depth; 1 to 21. The top LEVELS bits of each coordinate are used.
   localparam int LEVELS = 21;

   // Rotate/reflect levels handled by one pipeline stage.
   localparam int STEPS_PER_STAGE = 2;
   localparam int ROT_STEPS = LEVELS - 1;
   localparam int ROT_STAGES_RAW = (ROT_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int ROT_STAGES = (ROT_STAGES_RAW > 0) ? ROT_STAGES_RAW : 1;

   typedef logic [LEVELS-1:0] axis_type;
   // Entry 0 is x, 1 is y, 2 is z.
   typedef axis_type [AXES-1:0] point_type;

endpackage

// File: rtl/hi3d_rot_pipe.sv
module hi3d_rot_pipe (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hi3d_pkg::point_type  in_point,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hi3d_pkg::point_type  out_point
);

   localparam int Stages = hi3d_pkg::ROT_STAGES;

   // One rotate/reflect level at bit position b, all three axes in order.
   function automatic hi3d_pkg::point_type rot_level(hi3d_pkg::point_type pt,
                                                      int unsigned b);
      hi3d_pkg::point_type a;
      hi3d_pkg::axis_type  p;
      hi3d_pkg::axis_type  t;
      a = pt;
      p = (hi3d_pkg::axis_type'(1) << b) - hi3d_pkg::axis_type'(1);
      for (int i = 0; i < hi3d_pkg::AXES; i++) begin
         if (a[i][b]) begin
            a[0] = a[0] ^ p;
         end else begin
            t    = (a[0] ^ a[i]) & p;
            a[0] = a[0] ^ t;
            a[i] = a[i] ^ t;
         end
      end
      return a;
   endfunction

   logic [Stages-1:0]   valid_ff;
   logic [Stages-1:0]   valid_in;
   hi3d_pkg::point_type point_ff [Stages];
   hi3d_pkg::point_type point_in [Stages];
   logic [Stages:0]     load;

   // A stage loads when it is empty or its item moves on.
   assign load[Stages] = out_ready;
   assign in_ready     = load[0];
   assign out_valid    = valid_ff[Stages-1];
   assign out_point    = point_ff[Stages-1];

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      logic                src_valid;
      hi3d_pkg::point_type src_point;

      if (s == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_point = in_point;
      end else begin : g_next
         assign src_valid = valid_ff[s-1];
         assign src_point = point_ff[s-1];
      end

      assign load[s] = !valid_ff[s] || load[s+1];

      always_comb begin
         point_in[s] = src_point;
         for (int k = 0; k < hi3d_pkg::STEPS_PER_STAGE; k++) begin
            if (hi3d_pkg::LEVELS - 1 - (s * hi3d_pkg::STEPS_PER_STAGE + k) >= 1) begin
               point_in[s] = rot_level(point_in[s], int'(hi3d_pkg::LEVELS - 1 -
                                       (s * hi3d_pkg::STEPS_PER_STAGE + k)));
            end
         end
         valid_in[s] = load[s] ? src_valid : valid_ff[s];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_in[s];
         end
         if (load[s]) begin
            point_ff[s] <= point_in[s];
         end
      end
   end

   a_enter: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff[0])
      else $error("accepted item did not enter first stage");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !out_valid |-> in_ready)
      else $error("pipe refuses item while last stage is empty");

endmodule

// File: rtl/hi3d_gray_stage.sv
module hi3d_gray_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  hi3d_pkg::point_type           in_point,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [hi3d_pkg::INDEX_W-1:0]  out_index
);

   logic                          valid_ff;
   logic                          valid_in;
   logic [hi3d_pkg::INDEX_W-1:0]  index_ff;
   logic [hi3d_pkg::INDEX_W-1:0]  index_in;
   hi3d_pkg::point_type           gray;
   hi3d_pkg::axis_type            flip;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_index = index_ff;

   always_comb begin
      gray    = in_point;
      gray[1] = gray[1] ^ gray[0];
      gray[2] = gray[2] ^ gray[1];
      // Bit j flips when an odd count of gray[2] bits above j is set.
      for (int j = 0; j < hi3d_pkg::LEVELS; j++) begin
         flip[j] = ^(gray[2] >> (j + 1));
      end
      for (int i = 0; i < hi3d_pkg::AXES; i++) begin
         gray[i] = gray[i] ^ flip;
      end
      index_in = '0;
      for (int lv = 0; lv < hi3d_pkg::LEVELS; lv++) begin
         for (int i = 0; i < hi3d_pkg::AXES; i++) begin
            index_in[hi3d_pkg::AXES * lv + hi3d_pkg::AXES - 1 - i] = gray[i][lv];
         end
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready) begin
         index_ff <= index_in;
      end
   end

   a_fill: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> out_valid)
      else $error("accepted item lost in output stage");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |-> !in_ready)
      else $error("output stage loads while result is held");

endmodule

// File: rtl/hilbert_index_3d.sv
// Channel   Ports                                    Direction
// req       req_valid req_ready req_coord_x/y/z      in  (3 x 21 bit point)
// rsp       rsp_valid rsp_ready rsp_curve_index      out (63 bit index)
//
// One item per cycle sustained while rsp_ready stays high. The 20 rotate/reflect
// levels run two per stage over ROT_STAGES stages, then one Gray/interleave stage.
// Reset clears only the stage valid bits.
// Each stage loads when empty or when its item moves on, so bubbles close up
// and new items enter while a finished result waits at rsp.
module hilbert_index_3d (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [hi3d_pkg::COORD_W-1:0]  req_coord_x,
   input  logic [hi3d_pkg::COORD_W-1:0]  req_coord_y,
   input  logic [hi3d_pkg::COORD_W-1:0]  req_coord_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hi3d_pkg::INDEX_W-1:0]  rsp_curve_index
);

   hi3d_pkg::point_type req_point;
   hi3d_pkg::point_type rot_point;
   logic                rot_valid;
   logic                rot_ready;

   // Keep the top LEVELS bits of each coordinate.
   assign req_point[0] = req_coord_x[hi3d_pkg::COORD_W-1 -: hi3d_pkg::LEVELS];
   assign req_point[1] = req_coord_y[hi3d_pkg::COORD_W-1 -: hi3d_pkg::LEVELS];
   assign req_point[2] = req_coord_z[hi3d_pkg::COORD_W-1 -: hi3d_pkg::LEVELS];

   hi3d_rot_pipe u_rot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_point  (req_point),
      .out_valid (rot_valid),
      .out_ready (rot_ready),
      .out_point (rot_point)
   );

   hi3d_gray_stage u_gray (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .in_ready  (rot_ready),
      .in_point  (rot_point),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_index (rsp_curve_index)
   );

endmodule
